// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared types and constants of the polynomial bisection root finder.
// ----------------------------------------------------------------------------
package pbr_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned NUM_COEFS      = 5;
  localparam int unsigned COEF_IDX_W     = 3;
  localparam int unsigned ADDR_W         = 5;
  localparam int unsigned DEF_ITERATIONS = 32;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t coefs_t [NUM_COEFS];

  typedef enum logic [1:0] {
    ST_ZERO      = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_NO_CHANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_MUL,
    H_ADD,
    H_DONE
  } horner_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL_LO,
    S_EVAL_HI,
    S_BISECT,
    S_EVAL_MID,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } eval_res_t;

endpackage

// ===== src/pbr_horner.sv =====
// ----------------------------------------------------------------------------
// pbr_horner
// Horner evaluation of the quartic on one shared multiplier and saturating adder.
// ----------------------------------------------------------------------------
module pbr_horner #(
  parameter int unsigned FRAC_BITS = pbr_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pbr_pkg::word_t     x,
  input  pbr_pkg::coefs_t    coefs,
  output pbr_pkg::eval_res_t res
);
  import pbr_pkg::*;

  localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN32 = -64'sh0000_0000_8000_0000;

  horner_state_t      state, state_next;
  word_t              acc;
  word_t              xr;
  logic signed [63:0] prod;
  logic [COEF_IDX_W-1:0] k;

  logic signed [63:0] scaled;
  word_t              scaled_sat;
  logic signed [32:0] sum;
  word_t              acc_next;

  always_comb begin
    scaled = prod >>> FRAC_BITS;
    if (scaled > MAX32) begin
      scaled_sat = word_t'(MAX32[31:0]);
    end else if (scaled < MIN32) begin
      scaled_sat = word_t'(MIN32[31:0]);
    end else begin
      scaled_sat = scaled[31:0];
    end
    sum = {scaled_sat[31], scaled_sat} + {coefs[k][31], coefs[k]};
    if (sum[32] != sum[31]) begin
      acc_next = sum[32] ? word_t'(MIN32[31:0]) : word_t'(MAX32[31:0]);
    end else begin
      acc_next = sum[31:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state) inside
      H_IDLE, H_DONE: state_next = start ? H_MUL : H_IDLE;
      H_MUL:  state_next = H_ADD;
      H_ADD:  state_next = (k == '0) ? H_DONE : H_MUL;
      default: state_next = H_IDLE;
    endcase
  end

  always_comb begin
    res.done = (state == H_DONE);
    res.neg  = acc[DATA_W-1];
    res.zero = (acc == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state) inside
      H_IDLE, H_DONE: begin
        if (start) begin
          acc <= coefs[NUM_COEFS-1];
          xr  <= x;
          k   <= COEF_IDX_W'(NUM_COEFS - 2);
        end
      end
      H_MUL: prod <= acc * xr;
      H_ADD: begin
        acc <= acc_next;
        k   <= k - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/polynomial_bisection_root.sv =====
// ----------------------------------------------------------------------------
// polynomial_bisection_root
// Bisection root finder for a quartic with coefficients in APB registers.
// ----------------------------------------------------------------------------
// One interval beat yields one result beat. The polynomial is evaluated by
// Horner's scheme on a single shared multiplier, with a multiply step and an
// add step for each coefficient below the leading one, then a done step. An
// item needs two end-point evaluations and up to ITERATIONS midpoint
// evaluations. The result beat is offered in the same cycle as the block is
// ready again; an exact zero ends the search early, and an interval without a
// sign change skips the midpoint evaluations. The block takes one item at a
// time, and the result register lets the next interval be accepted while the
// last result waits to be taken; a new result is held back until that
// register is free.
module polynomial_bisection_root #(
  parameter int unsigned ITERATIONS = pbr_pkg::DEF_ITERATIONS,
  parameter int unsigned FRAC_BITS  = pbr_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pbr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          x_start,
  input  logic signed [31:0]          x_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          root,
  output logic [1:0]                  status
);
  import pbr_pkg::*;

  localparam int unsigned CNT_W = $clog2(ITERATIONS + 1);

  seq_state_t  state, state_next;
  coefs_t      coef;
  word_t       lo, hi, mid;
  logic        lo_neg, lo_zero;
  logic [CNT_W-1:0] cnt;
  word_t       res_root;
  status_t     res_status;

  logic        eval_start;
  word_t       eval_x;
  eval_res_t   ev;
  logic [COEF_IDX_W-1:0] reg_idx;
  logic signed [32:0]    mid_sum;
  word_t       mid_c;
  logic        no_change;
  logic        last_iter;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign prdata  = (reg_idx < COEF_IDX_W'(NUM_COEFS)) ? coef[reg_idx] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      if (reg_idx < COEF_IDX_W'(NUM_COEFS)) begin
        coef[reg_idx] <= pwdata;
      end
    end
  end

  pbr_horner #(
    .FRAC_BITS(FRAC_BITS)
  ) u_horner (
    .clk   (clk),
    .rst   (rst),
    .start (eval_start),
    .x     (eval_x),
    .coefs (coef),
    .res   (ev)
  );

  assign mid_sum   = {lo[31], lo} + {hi[31], hi};
  assign mid_c     = mid_sum[32:1];
  assign no_change = lo_zero || ev.zero || (ev.neg == lo_neg);
  assign last_iter = (cnt == CNT_W'(ITERATIONS));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_EVAL_LO;
      S_EVAL_LO:  if (ev.done) state_next = S_EVAL_HI;
      S_EVAL_HI: begin
        if (ev.done) state_next = no_change ? S_FINISH : S_BISECT;
      end
      S_BISECT:   state_next = S_EVAL_MID;
      S_EVAL_MID: begin
        if (ev.done) state_next = (ev.zero || last_iter) ? S_FINISH : S_BISECT;
      end
      S_FINISH:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    eval_start = 1'b0;
    eval_x     = x_start;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        eval_start = in_valid;
        eval_x     = x_start;
      end
      S_EVAL_LO: begin
        eval_start = ev.done;
        eval_x     = hi;
      end
      S_BISECT: begin
        eval_start = 1'b1;
        eval_x     = mid_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          lo  <= x_start;
          hi  <= x_end;
          cnt <= '0;
        end
      end
      S_EVAL_LO: begin
        if (ev.done) begin
          lo_neg  <= ev.neg;
          lo_zero <= ev.zero;
        end
      end
      S_EVAL_HI: begin
        if (ev.done) begin
          res_root   <= '0;
          res_status <= ST_NO_CHANGE;
        end
      end
      S_BISECT: begin
        mid <= mid_c;
        cnt <= cnt + 1'b1;
      end
      S_EVAL_MID: begin
        if (ev.done) begin
          res_root   <= mid;
          res_status <= ev.zero ? ST_ZERO : ST_LIMIT;
          if (ev.neg != lo_neg) begin
            hi <= mid;
          end else begin
            lo <= mid;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          root   <= res_root;
          status <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/pbr_checker.sv =====
// ----------------------------------------------------------------------------
// pbr_checker
// Port-level checks of the bisection root finder, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] root,
  input logic [1:0]  status
);
  import pbr_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(root) && $stable(status), "result beat changed while stalled")
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input accepted while busy")
  `ASSERT_IMPL(a_status_code, clk, rst, out_valid, status <= ST_NO_CHANGE, "undefined status code")
  `ASSERT_IMPL(a_no_change_root, clk, rst, out_valid && status == ST_NO_CHANGE, root == 32'd0 && pready, "no sign change result with nonzero root")

endmodule

bind polynomial_bisection_root pbr_checker u_pbr_checker (.*);

// ===== sim/polynomial_bisection_root_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polynomial_bisection_root_tb
// Self-checking bench for the bisection root finder. Coefficients are written
// over the register port in several settings. Interval beats come from a
// directed set and then from random intervals that mostly bracket a sign
// change. Each result beat is compared with a bisection computed in the bench.
// ----------------------------------------------------------------------------
module polynomial_bisection_root_tb;
  import pbr_pkg::*;

  localparam word_t Q_ONE = 32'sh0001_0000;
  localparam word_t WMAX  = 32'sh7fff_ffff;
  localparam word_t WMIN  = 32'sh8000_0000;
  localparam int    REG_STRIDE = 4;
  localparam int    SETTLE_CYCLES = 400;

  class root_scoreboard;
    typedef struct {
      word_t   root;
      status_t code;
    } root_result_t;

    word_t        coef [NUM_COEFS];
    root_result_t expected_roots [$];
    int           errors;

    function new();
      foreach (coef[k]) coef[k] = '0;
      errors = 0;
    endfunction

    function word_t clamp_word(longint v);
      if (v > longint'(WMAX)) return WMAX;
      if (v < longint'(WMIN)) return WMIN;
      return word_t'(v);
    endfunction

    function word_t poly_at(word_t x);
      longint acc;
      longint prod;
      acc = 0;
      for (int k = NUM_COEFS - 1; k >= 0; k--) begin
        prod = (acc * longint'(x)) >>> DEF_FRAC_BITS;
        acc = clamp_word(longint'(clamp_word(prod)) + longint'(coef[k]));
      end
      return word_t'(acc);
    endfunction

    function int sign_at(word_t x);
      word_t p;
      p = poly_at(x);
      return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
    endfunction

    function bit has_bracket(word_t a, word_t b);
      int sa;
      int sb;
      sa = sign_at(a);
      sb = sign_at(b);
      return (sa != 0) && (sb != 0) && (sa != sb);
    endfunction

    function void note_interval(word_t a, word_t b);
      root_result_t r;
      longint lo;
      longint hi;
      longint mid;
      int sl;
      int sm;
      lo = a;
      hi = b;
      mid = 0;
      r.code = ST_LIMIT;
      if (!has_bracket(a, b)) begin
        r.root = '0;
        r.code = ST_NO_CHANGE;
        expected_roots.push_back(r);
        return;
      end
      sl = sign_at(a);
      for (int i = 0; i < DEF_ITERATIONS; i++) begin
        mid = (lo + hi) >>> 1;
        sm = sign_at(word_t'(mid));
        if (sm == 0) begin
          r.code = ST_ZERO;
          break;
        end
        if (sm != sl) hi = mid;
        else lo = mid;
      end
      r.root = word_t'(mid);
      expected_roots.push_back(r);
    endfunction

    function void check_result(word_t got_root, logic [1:0] got_status);
      root_result_t r;
      if (expected_roots.size() == 0) begin
        $error("result beat with no interval pending: root %0d, status %0d",
               got_root, got_status);
        errors++;
        return;
      end
      r = expected_roots.pop_front();
      if (got_root !== r.root) begin
        $error("root: expected %0d, got %0d", r.root, got_root);
        errors++;
      end
      if (got_status !== r.code) begin
        $error("status: expected %0d, got %0d", r.code, got_status);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic signed [31:0]  x_start;
  logic signed [31:0]  x_end;
  logic                out_valid;
  logic                out_ready;
  logic signed [31:0]  root;
  logic [1:0]          status;

  bit                  steady;
  root_scoreboard      sb = new();

  polynomial_bisection_root DUT (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic word_t draw_value(int lo_shift, int hi_shift);
    return word_t'($urandom) >>> $urandom_range(hi_shift, lo_shift);
  endfunction

  task automatic program_coefs(input coefs_t c);
    for (int k = 0; k < NUM_COEFS; k++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(k * REG_STRIDE);
      pwdata  <= c[k];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.coef[k] = c[k];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== c[k]) begin
        $error("coef_%0d: expected %0d, got %0d", k, c[k], $signed(prdata));
        sb.errors++;
      end
    end
    // A write past the last coefficient must leave every coefficient alone.
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'($urandom_range(7, NUM_COEFS) * REG_STRIDE);
    pwdata  <= $urandom;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_interval(input word_t a, input word_t b);
    int gap;
    gap = steady ? 0 : $urandom_range(15, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_start  <= a;
    x_end    <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_interval(a, b);
  endtask

  task automatic run_random(input int count);
    word_t a;
    word_t b;
    int    tries;
    repeat (count) begin
      a = draw_value(0, 28);
      b = draw_value(0, 28);
      tries = 0;
      if ($urandom_range(9, 0) != 0) begin
        while (!sb.has_bracket(a, b) && tries < 24) begin
          a = draw_value(0, 28);
          b = draw_value(0, 28);
          tries++;
        end
      end
      send_interval(a, b);
    end
  endtask

  task automatic end_phase();
    in_valid <= 1'b0;
    while (sb.expected_roots.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    x_start  <= '0;
    x_end    <= '0;
    steady   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // With every coefficient at zero no interval can bracket a root.
    send_interval(-Q_ONE, Q_ONE);
    send_interval(WMIN, WMAX);
    end_phase();

    program_coefs('{-Q_ONE, Q_ONE, 32'sd0, 32'sd0, 32'sd0});
    send_interval(32'sd0, 2 * Q_ONE);
    send_interval(2 * Q_ONE, 32'sd0);
    send_interval(32'sd0, Q_ONE);
    send_interval(WMIN, WMAX);
    send_interval(WMAX, WMIN);
    send_interval(3 * Q_ONE / 2, 3 * Q_ONE);
    send_interval(-3 * Q_ONE, 5 * Q_ONE);
    end_phase();

    program_coefs('{WMAX, WMAX, WMAX, WMAX, WMAX});
    send_interval(WMIN, WMAX);
    send_interval(WMAX, WMIN);
    end_phase();

    program_coefs('{WMIN, WMIN, WMIN, WMIN, WMIN});
    send_interval(WMIN, WMAX);
    send_interval(-32'sd1, 32'sd1);
    send_interval(32'sd0, 32'sd0);
    end_phase();

    program_coefs('{32'sd0, -2 * Q_ONE, 32'sd0, Q_ONE, 32'sd0});
    send_interval(Q_ONE, 2 * Q_ONE);
    send_interval(-2 * Q_ONE, -Q_ONE);
    send_interval(-Q_ONE, Q_ONE);
    send_interval(WMIN, WMAX);
    end_phase();

    program_coefs('{4 * Q_ONE, 32'sd0, -5 * Q_ONE, 32'sd0, Q_ONE});
    send_interval(Q_ONE / 2, 3 * Q_ONE / 2);
    send_interval(3 * Q_ONE / 2, 3 * Q_ONE);
    send_interval(-3 * Q_ONE, 32'sd0);
    send_interval(-5 * Q_ONE / 2, -3 * Q_ONE / 2);
    end_phase();

    for (int ph = 0; ph < 10; ph++) begin
      steady = (ph % 3 == 2);
      if (ph % 4 == 0)
        program_coefs('{draw_value(0, 28), Q_ONE, 32'sd0, 32'sd0, 32'sd0});
      else
        program_coefs('{draw_value(8, 28), draw_value(8, 28), draw_value(8, 28),
                        draw_value(8, 28),
                        ($urandom_range(1, 0) ? draw_value(8, 28) : 32'sd0)});
      run_random(113);
      end_phase();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = steady ? 0 : $urandom_range(15, 0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(root, status);
    end
  end

  initial begin
    #60ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== polynomial_bisection_root.f =====
+incdir+src
src/pbr_pkg.sv
src/pbr_horner.sv
src/polynomial_bisection_root.sv
src/pbr_checker.sv
sim/polynomial_bisection_root_tb.sv
